@@ rtl/rmed_pkg.sv @@
// Shared types and constants for the running median core.
`default_nettype none
package rmed_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int COUNT_W  = 11;
    localparam int SEL_W    = 2 * SAMPLE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } rmed_state_t;

    typedef struct packed {
        logic                       insert;
        logic signed [SAMPLE_W-1:0] sample;
    } rmed_cmd_t;

endpackage
`default_nettype wire

@@ rtl/running_median_core.sv @@
// Running median top level: sorted slot chain, gather tree and output register.
//
// Each accepted sample is inserted into a chain of CAPACITY slots kept in
// ascending order; every slot compares the sample against its own value
// and takes its left neighbor's value, the sample, or holds. The two middle
// slots are then gathered by a registered radix-4 OR tree of ceil(log4(CAPACITY))
// levels, and twice the median lands in the output register. A new sample is
// not taken while the previous one is still passing through the gather tree;
// the input stalls until the previous result has moved to the output register.
// A sample offered with the store at CAPACITY is dropped and flagged with
// store_full. No clearing pass after reset.
`default_nettype none
module running_median_core #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [rmed_pkg::SAMPLE_W-1:0] sample,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [rmed_pkg::MEDIAN_W-1:0]      median_doubled,
    output logic [rmed_pkg::COUNT_W-1:0]              sample_count,
    output logic                                      store_full
);
    import rmed_pkg::*;

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int IW     = $clog2(CAPACITY);
    localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
    localparam int WW     = $clog2(LEVELS + 1);

    rmed_state_t state_reg;
    rmed_state_t state_next;
    logic [WW-1:0] wait_reg;
    logic [WW-1:0] wait_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full_reg;
    logic          full_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [MEDIAN_W-1:0]  median_reg;
    logic [COUNT_W-1:0]          count_out_reg;
    logic                        full_out_reg;

    logic          in_xfer;
    logic          is_full;
    logic          load_out;
    rmed_cmd_t     cmd;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] lo_wide;
    logic [CW-1:0] hi_wide;
    logic [IW-1:0] lo_idx;
    logic [IW-1:0] hi_idx;

    logic signed [SAMPLE_W-1:0] cell_value [CAPACITY];
    logic                       cell_move  [CAPACITY];
    logic [SEL_W-1:0]           cell_sel   [CAPACITY];
    logic [SEL_W-1:0]           root;

    assign is_full = count_reg == CW'(CAPACITY);
    assign in_xfer = in_valid && !in_stall;
    assign cmd     = {in_xfer && !is_full, sample};

    assign cnt_m1  = count_reg - CW'(1);
    assign lo_wide = cnt_m1 >> 1;
    assign hi_wide = count_reg >> 1;
    assign lo_idx  = lo_wide[IW-1:0];
    assign hi_idx  = hi_wide[IW-1:0];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [SAMPLE_W-1:0] lv;
        logic                       lm;
        if (i == 0)
        begin : g_first
            assign lv = '0;
            assign lm = 1'b0;
        end
        else
        begin : g_rest
            assign lv = cell_value[i-1];
            assign lm = cell_move[i-1];
        end
        rmed_cell #(
            .IDX (i),
            .CW  (CW),
            .IW  (IW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .lo_idx     (lo_idx),
            .hi_idx     (hi_idx),
            .left_value (lv),
            .left_move  (lm),
            .value      (cell_value[i]),
            .move       (cell_move[i]),
            .sel        (cell_sel[i])
        );
    end

    rmed_or_tree #(
        .LEAVES (CAPACITY),
        .W      (SEL_W)
    ) u_tree (
        .clk  (clk),
        .leaf (cell_sel),
        .root (root)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_BUSY;
            end
            ST_BUSY:
            begin
                if (wait_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall  = 1'b1;
        wait_next = wait_reg;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                wait_next = WW'(LEVELS - 1);
            end
            ST_BUSY:
            begin
                wait_next = wait_reg - WW'(1);
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign count_next     = cmd.insert ? count_reg + CW'(1) : count_reg;
    assign full_next      = in_xfer ? is_full : full_reg;
    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            count_reg     <= count_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            median_reg <= {root[SEL_W-1], root[SEL_W-1:SAMPLE_W]}
                        + {root[SAMPLE_W-1], root[SAMPLE_W-1:0]};
            count_out_reg <= COUNT_W'(count_reg);
            full_out_reg  <= full_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign median_doubled = median_reg;
    assign sample_count   = count_out_reg;
    assign store_full     = full_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("held count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !is_full) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("count did not advance on insertion");

    a_done_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> ($past(state_reg) == ST_BUSY
                                   || $past(state_reg) == ST_DONE))
        else $error("result ready without tree wait");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && store_full) |-> sample_count == COUNT_W'(CAPACITY))
        else $error("full flag with count below capacity");

    a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out) |-> count_reg != '0)
        else $error("result taken from empty store");

endmodule
`default_nettype wire

@@ rtl/rmed_cell.sv @@
// One slot of the sorted insertion chain.
`default_nettype none
module rmed_cell #(
    parameter int IDX = 0,
    parameter int CW  = 11,
    parameter int IW  = 10
) (
    input  wire logic                              clk,
    input  wire rmed_pkg::rmed_cmd_t               cmd,
    input  wire logic [CW-1:0]                     count,
    input  wire logic [IW-1:0]                     lo_idx,
    input  wire logic [IW-1:0]                     hi_idx,
    input  wire logic signed [rmed_pkg::SAMPLE_W-1:0] left_value,
    input  wire logic                              left_move,
    output logic signed [rmed_pkg::SAMPLE_W-1:0]   value,
    output logic                                   move,
    output logic [rmed_pkg::SEL_W-1:0]             sel
);
    import rmed_pkg::*;

    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;
    logic                       occupied;
    logic                       at_end;

    assign occupied = CW'(IDX) < count;
    assign at_end   = CW'(IDX) == count;
    assign move     = occupied && (value_reg > cmd.sample);
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.insert)
        begin
            if (left_move)
                value_next = left_value;
            else if (move || at_end)
                value_next = cmd.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // upper half: sample at hi_idx, lower half: sample at lo_idx
    assign sel = {(IW'(IDX) == hi_idx) ? value_reg : {SAMPLE_W{1'b0}},
                  (IW'(IDX) == lo_idx) ? value_reg : {SAMPLE_W{1'b0}}};

endmodule
`default_nettype wire

@@ rtl/rmed_or_tree.sv @@
// Registered radix-4 OR tree that gathers the selected slot values.
`default_nettype none
module rmed_or_tree #(
    parameter int LEAVES = 1024,
    parameter int W      = 64
) (
    input  wire logic         clk,
    input  wire logic [W-1:0] leaf [LEAVES],
    output logic [W-1:0]      root
);
    localparam int LEVELS = ($clog2(LEAVES) + 1) / 2;
    localparam int PADDED = 4 ** LEVELS;
    localparam int INNER  = (PADDED - 1) / 3;

    logic [W-1:0] node_reg  [INNER];
    logic [W-1:0] node_next [INNER];

    for (genvar i = 0; i < INNER; i++)
    begin : g_node
        logic [W-1:0] child [4];
        for (genvar k = 0; k < 4; k++)
        begin : g_child
            localparam int C = 4 * i + 1 + k;
            if (C < INNER)
            begin : g_inner
                assign child[k] = node_reg[C];
            end
            else if (C - INNER < LEAVES)
            begin : g_leaf
                assign child[k] = leaf[C - INNER];
            end
            else
            begin : g_pad
                assign child[k] = '0;
            end
        end
        assign node_next[i] = child[0] | child[1] | child[2] | child[3];
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
    end

    assign root = node_reg[0];

endmodule
`default_nettype wire
